### src/lre_pkg.sv
// Package for the LED ring effect engine: widths, effect codes, queue entry type.
// No dependencies.
package lre_pkg;
   localparam int MaxLeds = 32;
   localparam int IdxW = 5;
   localparam int CntW = 6;
   localparam logic [23:0] SocLowColor = 24'h000040;
   localparam logic [23:0] SocHighColor = 24'h004000;
   localparam logic [7:0] SocDimPeriod = 8'd5;
   localparam int QDepth = 2;

   typedef enum logic [3:0] {
      FX_OFF = 4'd0, FX_ON = 4'd1, FX_BAR = 4'd2, FX_DIMBAR = 4'd3, FX_BLINKBAR = 4'd4,
      FX_LEADBLINK = 4'd5, FX_BARANIM = 4'd6, FX_DOT = 4'd7, FX_DOTANIM = 4'd8,
      FX_CCWBAR = 4'd9, FX_CCWANIM = 4'd10, FX_BINARY = 4'd11, FX_SOC = 4'd12
   } fx_type;

   typedef enum logic [0:0] {CSR_LED_COUNT = 1'b0, CSR_FULL_BRIGHT = 1'b1} csr_type;

   typedef struct packed {
      logic        frame;
      logic        layer;
      logic [3:0]  kind;
      logic [7:0]  param;
      logic [23:0] color;
      logic [7:0]  period;
      logic        rst_pos;
   } cmd_type;

   typedef enum logic [1:0] {ST_IDLE, ST_ADV, ST_EMIT} state_type;
endpackage

### src/lre_front.sv
// Front end: accepts request items, drops invalid effect kinds, queues commands.
// Depends on lre_pkg.
module lre_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  lre_pkg::cmd_type in_cmd,
   output logic             q_valid,
   input  logic             q_pop,
   output lre_pkg::cmd_type q_cmd
);
   import lre_pkg::*;

   cmd_type    mem_ff [QDepth];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign in_stall = (cnt_ff == 2'(QDepth));
   assign push = in_valid && !in_stall && (in_cmd.frame || in_cmd.kind <= FX_SOC);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? !wr_ff : wr_ff;
      rd_in = q_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_cmd;
   end
endmodule

### src/lre_back.sv
// Back end: holds layer state, advances it per frame, emits one pixel per cycle unless rsp_stall holds it.
// Depends on lre_pkg.
module lre_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_pop,
   input  lre_pkg::cmd_type q_cmd,
   input  logic [5:0]       led_count,
   input  logic [7:0]       full_bright,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [4:0]       rsp_led_index,
   output logic [23:0]      rsp_pixel_color,
   output logic             rsp_last_pixel
);
   import lre_pkg::*;

   state_type   state_ff, state_in;
   logic [3:0]  kind_ff [2];
   logic [7:0]  param_ff [2];
   logic [23:0] color_ff [2];
   logic [7:0]  period_ff [2];
   logic [7:0]  pos_ff [2];
   logic [7:0]  fss_ff [2];
   logic        dim_ff [2], blink_ff [2], lead_ff [2];
   logic [7:0]  bri_ff [2];
   logic [7:0]  rem_ff [2];
   logic [5:0]  dv_ff [2];
   logic        stp_ff [2];
   logic [3:0]  k_ff, k_in;
   logic [CntW-1:0] n_ff;
   logic [CntW-1:0] i_ff, i_in;
   logic        ov_ff, ov_in;
   logic [4:0]  oi_ff;
   logic [23:0] oc_ff;
   logic        ol_ff;
   logic        emit;
   logic [CntW-1:0] n_lim;
   logic [7:0]  dim_b;
   logic [23:0] pc [2];
   logic [23:0] sel_c;
   logic [7:0]  sel_b;

   assign n_lim = (led_count > CntW'(MaxLeds)) ? CntW'(MaxLeds) : led_count;
   assign dim_b = 8'((16'(full_bright) * 16'd171) >> 9);
   assign rsp_valid = ov_ff;
   assign rsp_led_index = oi_ff;
   assign rsp_pixel_color = oc_ff;
   assign rsp_last_pixel = ol_ff;

   function automatic logic [23:0] bar(input logic [CntW-1:0] i, input logic [7:0] len,
                                        input logic [23:0] c);
      return (8'(i) < len) ? c : 24'd0;
   endfunction

   function automatic logic [23:0] ccw(input logic [CntW-1:0] i, input logic [CntW-1:0] n,
                                        input logic [7:0] len, input logic [23:0] c);
      logic signed [9:0] d;
      d = $signed({4'd0, n}) - $signed({2'd0, len});
      if (i == '0) return (len != 8'd0) ? c : 24'd0;
      return (d < $signed({4'd0, i})) ? c : 24'd0;
   endfunction

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         pc[l] = 24'd0;
         unique case (kind_ff[l])
            FX_ON: pc[l] = color_ff[l];
            FX_BAR, FX_DIMBAR, FX_BLINKBAR: pc[l] = bar(i_ff, param_ff[l], color_ff[l]);
            FX_LEADBLINK:
               if (lead_ff[l] && param_ff[l] != 8'd0 && param_ff[l] <= 8'(n_ff)
                   && 8'(i_ff) == param_ff[l] - 8'd1) pc[l] = 24'd0;
               else pc[l] = bar(i_ff, param_ff[l], color_ff[l]);
            FX_BARANIM: pc[l] = bar(i_ff, pos_ff[l], color_ff[l]);
            FX_DOT: pc[l] = (8'(i_ff) == param_ff[l]) ? color_ff[l] : 24'd0;
            FX_DOTANIM: pc[l] = (8'(i_ff) == pos_ff[l]) ? color_ff[l] : 24'd0;
            FX_CCWBAR: pc[l] = ccw(i_ff, n_ff, param_ff[l], color_ff[l]);
            FX_CCWANIM: pc[l] = ccw(i_ff, n_ff, pos_ff[l], color_ff[l]);
            FX_BINARY: pc[l] = (i_ff < CntW'(8) && param_ff[l][i_ff[2:0]]) ? color_ff[l] : 24'd0;
            FX_SOC: pc[l] = bar(i_ff, param_ff[l], (param_ff[l] <= 8'd2) ? SocLowColor
                                                                          : SocHighColor);
            default: pc[l] = 24'd0;
         endcase
      end
      sel_c = 24'd0;
      sel_b = 8'd0;
      for (int l = 0; l < 2; l++) begin
         if (pc[l] != 24'd0 && bri_ff[l] != 8'd0) begin
            sel_c = pc[l];
            sel_b = bri_ff[l];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      q_pop = 1'b0;
      emit = 1'b0;
      i_in = i_ff;
      k_in = k_ff;
      unique case (state_ff)
         ST_IDLE:
            if (q_valid) begin
               if (q_cmd.frame) begin
                  state_in = ST_ADV;
                  k_in = 4'd8;
               end else q_pop = 1'b1;
            end
         ST_ADV:
            if (k_ff != 4'd0) k_in = k_ff - 4'd1;
            else begin
               i_in = '0;
               if (n_lim == '0) begin
                  q_pop = 1'b1;
                  state_in = ST_IDLE;
               end else state_in = ST_EMIT;
            end
         ST_EMIT:
            if (!ov_ff || !rsp_stall) begin
               emit = 1'b1;
               i_in = i_ff + CntW'(1);
               if (i_ff + CntW'(1) == n_ff) begin
                  q_pop = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         default: state_in = ST_IDLE;
      endcase
      ov_in = emit ? 1'b1 : (ov_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff <= 1'b0;
         i_ff <= '0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
         i_ff <= i_in;
         k_ff <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         oi_ff <= i_ff[4:0];
         oc_ff <= {8'((16'(sel_c[23:16]) * 16'(sel_b)) >> 8),
                   8'((16'(sel_c[15:8]) * 16'(sel_b)) >> 8),
                   8'((16'(sel_c[7:0]) * 16'(sel_b)) >> 8)};
         ol_ff <= (i_ff + CntW'(1) == n_ff);
      end
   end

   always_ff @(posedge clock) begin
      logic [7:0]  f, per, p1;
      logic        due;
      logic [13:0] sh;
      if (reset) begin
         for (int l = 0; l < 2; l++) begin
            kind_ff[l] <= FX_OFF; param_ff[l] <= '0; color_ff[l] <= '0;
            period_ff[l] <= '0; pos_ff[l] <= '0; fss_ff[l] <= '0;
            dim_ff[l] <= 1'b0; blink_ff[l] <= 1'b0; lead_ff[l] <= 1'b0;
            bri_ff[l] <= 8'd77;
            stp_ff[l] <= 1'b0;
         end
         n_ff <= '0;
      end else if (state_ff == ST_IDLE && q_valid && !q_cmd.frame) begin
         kind_ff[q_cmd.layer] <= q_cmd.kind;
         param_ff[q_cmd.layer] <= q_cmd.param;
         color_ff[q_cmd.layer] <= q_cmd.color;
         period_ff[q_cmd.layer] <= q_cmd.period;
         if (q_cmd.rst_pos) pos_ff[q_cmd.layer] <= '0;
      end else if (state_ff == ST_IDLE && q_valid) begin
         n_ff <= n_lim;
         for (int l = 0; l < 2; l++) begin
            f = (fss_ff[l] == 8'hFF) ? fss_ff[l] : fss_ff[l] + 8'd1;
            per = (kind_ff[l] == FX_SOC) ? SocDimPeriod : period_ff[l];
            due = (f >= per);
            p1 = pos_ff[l] + 8'd1;
            fss_ff[l] <= f;
            stp_ff[l] <= due && (kind_ff[l] inside {FX_BARANIM, FX_DOTANIM, FX_CCWANIM});
            rem_ff[l] <= (kind_ff[l] == FX_CCWANIM) ? pos_ff[l] : p1;
            dv_ff[l] <= (kind_ff[l] == FX_BARANIM) ? n_lim + CntW'(1) : n_lim;
            unique case (kind_ff[l])
               FX_DIMBAR, FX_BLINKBAR, FX_LEADBLINK, FX_BARANIM, FX_DOTANIM, FX_CCWANIM:
                  if (due) fss_ff[l] <= '0;
               FX_SOC:
                  if (param_ff[l] <= 8'd1 && due) fss_ff[l] <= '0;
               default: ;
            endcase
            unique case (kind_ff[l])
               FX_DIMBAR:
                  if (due) begin
                     dim_ff[l] <= !dim_ff[l];
                     bri_ff[l] <= !dim_ff[l] ? full_bright : dim_b;
                  end
               FX_SOC:
                  if (param_ff[l] > 8'd1) bri_ff[l] <= full_bright;
                  else if (due) begin
                     dim_ff[l] <= !dim_ff[l];
                     bri_ff[l] <= !dim_ff[l] ? full_bright : dim_b;
                  end
               FX_BLINKBAR:
                  if (due) begin
                     blink_ff[l] <= !blink_ff[l];
                     bri_ff[l] <= !blink_ff[l] ? full_bright : 8'd0;
                  end
               FX_LEADBLINK: begin
                  bri_ff[l] <= full_bright;
                  if (due) lead_ff[l] <= !lead_ff[l];
               end
               FX_CCWBAR: ;
               default: bri_ff[l] <= full_bright;
            endcase
         end
      end else if (state_ff == ST_ADV) begin
         for (int l = 0; l < 2; l++) begin
            if (k_ff != 4'd0) begin
               sh = 14'(dv_ff[l]) << (k_ff - 4'd1);
               if (14'(rem_ff[l]) >= sh) rem_ff[l] <= rem_ff[l] - sh[7:0];
            end else if (stp_ff[l]) begin
               unique case (kind_ff[l])
                  FX_BARANIM: pos_ff[l] <= rem_ff[l];
                  FX_DOTANIM: pos_ff[l] <= (n_ff == '0) ? 8'd0 : rem_ff[l];
                  default: pos_ff[l] <= ((n_ff == '0) ? 8'd0 : rem_ff[l]) + 8'd1;
               endcase
            end
         end
      end
   end
endmodule

### src/led_ring_effect_engine.sv
// LED ring effect engine top level: config registers, front queue, back engine.
// Depends on lre_pkg, lre_front, lre_back.
// A frame item holds the back engine while it advances the layers, then the position remainder,
// then emits one pixel per cycle unless rsp_stall holds it; a set-effect item is popped from idle.
// Synchronous reset empties the queue, turns both layers off, sets led_count to 0 and full brightness to 77.
module led_ring_effect_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic        req_layer,
   input  logic [3:0]  req_effect_kind,
   input  logic [7:0]  req_effect_param,
   input  logic [23:0] req_effect_color,
   input  logic [7:0]  req_effect_period,
   input  logic        req_reset_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_led_index,
   output logic [23:0] rsp_pixel_color,
   output logic        rsp_last_pixel,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);
   import lre_pkg::*;

   logic [5:0] led_count_ff;
   logic [7:0] full_ff;
   cmd_type    in_cmd, q_cmd;
   logic       q_valid, q_pop;

   assign csr_ready = 1'b1;
   assign in_cmd = '{frame: req_mode, layer: req_layer, kind: req_effect_kind,
                     param: req_effect_param, color: req_effect_color,
                     period: req_effect_period, rst_pos: req_reset_position};

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= '0;
         full_ff <= 8'd77;
      end else if (csr_valid) begin
         unique case (csr_type'(csr_index))
            CSR_LED_COUNT: led_count_ff <= csr_data[5:0];
            CSR_FULL_BRIGHT: full_ff <= csr_data;
            default: ;
         endcase
      end
   end

   lre_front u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall), .in_cmd,
      .q_valid, .q_pop, .q_cmd
   );

   lre_back u_back (
      .clock, .reset, .q_valid, .q_pop, .q_cmd, .led_count(led_count_ff),
      .full_bright(full_ff), .rsp_valid, .rsp_stall, .rsp_led_index,
      .rsp_pixel_color, .rsp_last_pixel
   );
endmodule

### src/lre_checker.sv
// Port-level checker for the LED ring effect engine, bound to the top level.
// Depends on led_ring_effect_engine ports only.
module lre_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [4:0]  rsp_led_index,
   input logic [23:0] rsp_pixel_color,
   input logic        rsp_last_pixel
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_color))
      else $error("stalled item changed");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_pixel ##1 rsp_valid |->
      rsp_led_index == $past(rsp_led_index) + 5'd1)
      else $error("pixel index skipped");
   a_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_pixel ##1 rsp_valid |-> rsp_led_index == 5'd0)
      else $error("frame did not start at zero");
endmodule

bind led_ring_effect_engine lre_checker u_chk (.*);

### sim/tb_led_ring_effect_engine.sv
// Testbench for led_ring_effect_engine: table-driven directed items, then random bursts,
// checked pixel by pixel against a behavioral predictor of both effect layers.
// Depends on lre_pkg and the led_ring_effect_engine RTL.
module tb_led_ring_effect_engine;
   timeunit 1ns;
   timeprecision 1ps;
   import lre_pkg::*;

   typedef struct {
      logic        mode;
      logic        layer;
      logic [3:0]  kind;
      logic [7:0]  param;
      logic [23:0] color;
      logic [7:0]  period;
      logic        rst_pos;
   } fx_item_t;

   typedef struct {
      logic [4:0]  idx;
      logic [23:0] color;
      logic        last;
   } pixel_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_mode = 1'b0, req_layer = 1'b0, req_reset_position = 1'b0;
   logic [3:0] req_effect_kind = '0;
   logic [7:0] req_effect_param = '0, req_effect_period = '0;
   logic [23:0] req_effect_color = '0;
   logic req_stall, rsp_valid, rsp_last_pixel, csr_ready;
   logic rsp_stall = 1'b0;
   logic [4:0] rsp_led_index;
   logic [23:0] rsp_pixel_color;
   logic csr_valid = 1'b0, csr_index = 1'b0;
   logic [7:0] csr_data = '0;

   led_ring_effect_engine DUT (.*);

   always #6 clock = ~clock;

   int unsigned ring_leds = 0;
   logic [7:0] bright_full = 8'd77;
   logic [3:0] lk[2];
   logic [7:0] lp[2], lper[2], lpos[2], lfr[2], lbr[2];
   logic [23:0] lc[2];
   logic dimt[2], blkt[2], ldt[2];

   pixel_t pixels_due[$];
   int errors = 0, frames_sent = 0, pixels_seen = 0;
   bit stall_en = 1'b0;

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic bit step_due(int l, logic [7:0] per);
      if (lfr[l] >= per) begin
         lfr[l] = 8'd0;
         return 1;
      end
      return 0;
   endfunction

   function automatic void advance_layer(int l, int unsigned n);
      int unsigned pos;
      if (lfr[l] < 255) lfr[l]++;
      case (fx_type'(lk[l]))
         FX_DIMBAR: if (step_due(l, lper[l])) begin
            dimt[l] = ~dimt[l];
            lbr[l] = dimt[l] ? bright_full : 8'(bright_full / 3);
         end
         FX_BLINKBAR: if (step_due(l, lper[l])) begin
            blkt[l] = ~blkt[l];
            lbr[l] = blkt[l] ? bright_full : 8'd0;
         end
         FX_LEADBLINK: begin
            lbr[l] = bright_full;
            if (step_due(l, lper[l])) ldt[l] = ~ldt[l];
         end
         FX_BARANIM: begin
            lbr[l] = bright_full;
            if (step_due(l, lper[l])) begin
               pos = (lpos[l] + 1) & 8'hFF;
               lpos[l] = 8'(pos % (n + 1));
            end
         end
         FX_DOTANIM: begin
            lbr[l] = bright_full;
            if (step_due(l, lper[l])) begin
               pos = (lpos[l] + 1) & 8'hFF;
               lpos[l] = 8'(n ? pos % n : 0);
            end
         end
         FX_CCWANIM: begin
            lbr[l] = bright_full;
            if (step_due(l, lper[l])) begin
               pos = n ? lpos[l] % n : 0;
               lpos[l] = 8'(pos + 1);
            end
         end
         FX_CCWBAR: ;
         FX_SOC: if (lp[l] <= 1) begin
            if (step_due(l, SocDimPeriod)) begin
               dimt[l] = ~dimt[l];
               lbr[l] = dimt[l] ? bright_full : 8'(bright_full / 3);
            end
         end else lbr[l] = bright_full;
         default: lbr[l] = bright_full;
      endcase
   endfunction

   function automatic logic [23:0] bar(int unsigned i, int unsigned len, logic [23:0] c);
      return i < len ? c : 24'd0;
   endfunction

   function automatic logic [23:0] ccw(int unsigned i, int unsigned n, int unsigned len,
                                       logic [23:0] c);
      if (i == 0) return len ? c : 24'd0;
      return (int'(n) - int'(len)) < int'(i) ? c : 24'd0;
   endfunction

   function automatic logic [23:0] layer_color_at(int l, int unsigned i, int unsigned n);
      logic [23:0] c = lc[l];
      int unsigned q = lp[l];
      case (fx_type'(lk[l]))
         FX_ON: return c;
         FX_BAR, FX_DIMBAR, FX_BLINKBAR: return bar(i, q, c);
         FX_LEADBLINK: begin
            if (ldt[l] && q != 0 && q <= n && i == q - 1) return 24'd0;
            return bar(i, q, c);
         end
         FX_BARANIM: return bar(i, lpos[l], c);
         FX_DOT: return i == q ? c : 24'd0;
         FX_DOTANIM: return i == lpos[l] ? c : 24'd0;
         FX_CCWBAR: return ccw(i, n, q, c);
         FX_CCWANIM: return ccw(i, n, lpos[l], c);
         FX_BINARY: return (i < 8 && q[i]) ? c : 24'd0;
         FX_SOC: return bar(i, q, q <= 2 ? SocLowColor : SocHighColor);
         default: return 24'd0;
      endcase
   endfunction

   function automatic void predict_frame(fx_item_t it);
      int unsigned n;
      logic [23:0] c, px;
      pixel_t p;
      if (it.mode == 1'b0) begin
         if (it.kind > 4'd12) return;
         lk[it.layer] = it.kind;
         lp[it.layer] = it.param;
         lc[it.layer] = it.color;
         lper[it.layer] = it.period;
         if (it.rst_pos) lpos[it.layer] = 8'd0;
         return;
      end
      n = ring_leds > MaxLeds ? MaxLeds : ring_leds;
      for (int l = 0; l < 2; l++) advance_layer(l, n);
      for (int unsigned i = 0; i < n; i++) begin
         px = 0;
         for (int l = 0; l < 2; l++) begin
            c = layer_color_at(l, i, n);
            if (c != 0 && lbr[l] != 0)
               for (int s = 0; s < 24; s += 8)
                  px[s+:8] = 8'((32'(c[s+:8]) * 32'(lbr[l])) >> 8);
         end
         p.idx = i[4:0];
         p.color = px;
         p.last = (i + 1 == n);
         pixels_due.push_back(p);
      end
   endfunction

   task automatic send(fx_item_t it);
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_layer <= it.layer;
      req_effect_kind <= it.kind;
      req_effect_param <= it.param;
      req_effect_color <= it.color;
      req_effect_period <= it.period;
      req_reset_position <= it.rst_pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_frame(it);
      if (it.mode) frames_sent++;
   endtask

   task automatic gap();
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      gap();
      @(posedge clock);
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(csr_type idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_LED_COUNT) ring_leds = 32'(val[5:0]);
      else bright_full = val;
   endtask

   function automatic fx_item_t frame_item();
      fx_item_t it;
      it.mode = 1;
      it.layer = 1'($urandom);
      it.kind = 4'($urandom);
      it.param = 8'($urandom);
      it.color = 24'($urandom);
      it.period = 8'($urandom);
      it.rst_pos = 1'($urandom);
      return it;
   endfunction

   function automatic fx_item_t rand_effect();
      fx_item_t it = frame_item();
      it.mode = 0;
      if ($urandom_range(9) == 0) it.kind = 4'($urandom_range(15, 13));
      else it.kind = 4'($urandom_range(12));
      case ($urandom_range(3))
         0: it.param = 8'($urandom_range(3));
         1: it.param = 8'($urandom_range(40));
         default: ;
      endcase
      if ($urandom_range(2) != 0) it.period = 8'($urandom_range(3));
      if ($urandom_range(3) == 0) it.color = 24'hFFFFFF;
      return it;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            pixels_seen++;
            if (pixels_due.size() == 0) report("unexpected pixel", 32'(rsp_led_index), 0);
            else begin
               pixel_t w;
               w = pixels_due.pop_front();
               if (rsp_led_index !== w.idx)
                  report("led_index", 32'(rsp_led_index), 32'(w.idx));
               if (rsp_pixel_color !== w.color)
                  report("pixel_color", 32'(rsp_pixel_color), 32'(w.color));
               if (rsp_last_pixel !== w.last)
                  report("last_pixel", 32'(rsp_last_pixel), 32'(w.last));
            end
         end
         rsp_stall <= stall_en && ($urandom_range(3) == 0);
      end
   end

   initial begin
      #50ms;
      $display("Test completed with failures");
      $finish;
   end

   fx_item_t directed[$] = '{
      '{1, 0, 0, 0, 0, 0, 0},
      '{0, 0, FX_ON, 0, 24'hFFFFFF, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0},
      '{0, 1, FX_BAR, 8'd5, 24'h123456, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0},
      '{0, 1, 4'd13, 0, 24'hFFFFFF, 0, 0},
      '{0, 1, 4'd15, 8'hFF, 24'hFFFFFF, 8'hFF, 1},
      '{0, 0, FX_DIMBAR, 8'd10, 24'h808080, 8'd1, 0},
      '{1, 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0},
      '{0, 1, FX_BLINKBAR, 8'd3, 24'hFF00FF, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0},
      '{0, 1, FX_LEADBLINK, 8'd4, 24'h00FF00, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0},
      '{0, 0, FX_BARANIM, 0, 24'h0000FF, 0, 1},
      '{0, 1, FX_DOT, 8'hFF, 24'hFFFFFF, 8'hFF, 0},
      '{1, 0, 0, 0, 0, 0, 0},
      '{0, 1, FX_DOTANIM, 0, 24'h010101, 8'd2, 1},
      '{1, 0, 0, 0, 0, 0, 0},
      '{0, 1, FX_CCWBAR, 8'd3, 24'hA5A5A5, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0},
      '{0, 1, FX_CCWANIM, 0, 24'h5A5A5A, 0, 1},
      '{1, 0, 0, 0, 0, 0, 0},
      '{0, 1, FX_BINARY, 8'hA5, 24'hFFFFFF, 0, 0},
      '{0, 0, FX_SOC, 8'd1, 0, 0, 0}
   };

   initial begin
      int bursts;
      int unsigned counts[5] = '{8, 32, 63, 0, 1};
      for (int l = 0; l < 2; l++) begin
         lk[l] = 0; lp[l] = 0; lc[l] = 0; lper[l] = 0; lpos[l] = 0; lfr[l] = 0;
         dimt[l] = 0; blkt[l] = 0; ldt[l] = 0; lbr[l] = 8'd77;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_csr(CSR_LED_COUNT, 8'd8);
      foreach (directed[k]) send(directed[k]);
      drain();
      write_csr(CSR_FULL_BRIGHT, 8'd255);
      stall_en = 1'b1;
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            write_csr(CSR_LED_COUNT, 8'(counts[ph % 5]));
            write_csr(CSR_FULL_BRIGHT, ph == 3 ? 8'd0 : 8'($urandom));
         end
         bursts = 0;
         while (bursts < 55) begin
            int len = $urandom_range(6, 1);
            for (int k = 0; k < len; k++)
               send(($urandom_range(2) == 0) ? rand_effect() : frame_item());
            bursts += len;
            if ($urandom_range(1)) begin
               gap();
               repeat ($urandom_range(5, 1)) @(posedge clock);
            end
         end
         drain();
      end
      stall_en = 1'b0;
      drain();
      $display("Covered %0d frames and %0d pixels across six LED count and brightness settings",
               frames_sent, pixels_seen);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
